[rtl/core/tral_pkg.sv]
`default_nettype none

package tral_pkg;

  localparam int ZOOM_W  = 5;
  localparam int COORD_W = 20;
  localparam int ADDR_W  = 48;
  localparam int SLOT_W  = 4;
  localparam int FNUM_W  = 3;

  localparam int RANGE_SLOTS_DEFAULT = 16;
  localparam int FILE_SLOTS_DEFAULT  = 8;

  // Zoom levels 0 through 20 exist; a higher zoom never matches a range.
  localparam logic [ZOOM_W-1:0] ZOOM_LEVELS = 5'd21;

  localparam logic [1:0] OP_LOAD_RANGE = 2'd0;
  localparam logic [1:0] OP_LOAD_FILE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP     = 2'd2;
  localparam logic [1:0] OP_MAP        = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_RANGE = 2'd1;
  localparam logic [1:0] STATUS_BEYOND   = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_RANGES_IN_USE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILES_IN_USE  = 2'd1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [SLOT_W-1:0]  slot;
    logic [ZOOM_W-1:0]  zoom;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic [ADDR_W-1:0]  base_offset;
    logic [ADDR_W-1:0]  file_size;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [ADDR_W-1:0]  global_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] entry_address;
    logic [FNUM_W-1:0] file_number;
    logic [ADDR_W-1:0] file_offset;
  } out_item_t;

  // One stored range: zoom, bounds and base offset side by side.
  typedef struct packed {
    logic [ZOOM_W-1:0]  zoom;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] min_y;
    logic [ADDR_W-1:0]  base;
  } range_entry_t;

endpackage

`default_nettype wire

[rtl/core/tile_range_address_lookup_core.sv]
`default_nettype none

// Tile index address lookup. Every input transaction gives exactly one result
// transaction, and items are worked on one at a time. A load of a range or a
// file size goes straight to its result. A lookup with a valid zoom scans the
// range memory one entry a cycle, in slot order, starting at slot 0 and stopping
// at the first match or after ranges_in_use entries (at most RANGE_SLOTS); it
// then works out the entry address in S_MUL, S_SUM and S_ADDR (multiply, add,
// scale and base add) and scans the file-size memory one entry a cycle to find
// the split file. A map-address item does only the file-size scan. The single
// read port of each memory sets the scan speed. A result that waits on
// out_stall holds the next item back only once that item's own result is
// ready. Configuration is accepted every cycle.

module tile_range_address_lookup_core
  import tral_pkg::*;
#(
  parameter int RANGE_SLOTS = RANGE_SLOTS_DEFAULT,
  parameter int FILE_SLOTS  = FILE_SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RAW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int FAW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int RCW = $clog2(RANGE_SLOTS + 1);
  localparam int FCW = $clog2(FILE_SLOTS + 1);
  localparam int RLW = (RCW > 5) ? RCW : 5;
  localparam int FLW = (FCW > 4) ? FCW : 4;
  localparam int RANGE_W = $bits(range_entry_t);
  localparam int PROD_W = 2 * COORD_W + 1;
  localparam int SUM_W = PROD_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RSCAN  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_ADDR   = 3'd4;
  localparam logic [2:0] S_FSCAN  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]         state;
  logic [4:0]         ranges_in_use;
  logic [3:0]         files_in_use;
  logic [RLW-1:0]     range_limit;
  logic [FLW-1:0]     file_limit;

  logic [ZOOM_W-1:0]  lk_zoom;
  logic [COORD_W-1:0] lk_x;
  logic [COORD_W-1:0] lk_y;

  logic [RLW-1:0]     r_issue;
  logic               r_rvalid;
  logic [FLW-1:0]     f_issue;
  logic               f_rvalid;
  logic [FAW-1:0]     f_cmp;

  logic [COORD_W-1:0] hit_x0;
  logic [COORD_W-1:0] hit_y0;
  logic [COORD_W-1:0] hit_y1;
  logic [ADDR_W-1:0]  hit_base;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   idx_sum;
  logic [ADDR_W-1:0]  entry;
  logic [ADDR_W-1:0]  rest;
  logic [1:0]         res_status;
  logic [FNUM_W-1:0]  res_fnum;
  logic [ADDR_W-1:0]  res_foff;

  logic               in_accept;
  logic               range_we;
  logic               file_we;
  range_entry_t       range_wdata;
  logic [RANGE_W-1:0] range_rbits;
  range_entry_t       range_rd;
  logic [ADDR_W-1:0]  file_rd;
  logic               range_hit;
  logic               r_more;
  logic               f_more;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign range_limit = (RLW'(ranges_in_use) > RLW'(RANGE_SLOTS)) ?
                       RLW'(RANGE_SLOTS) : RLW'(ranges_in_use);
  assign file_limit  = (FLW'(files_in_use) > FLW'(FILE_SLOTS)) ?
                       FLW'(FILE_SLOTS) : FLW'(files_in_use);

  // Loads go straight into the memories at the accepting edge.
  assign range_we = in_accept && (in_item.opcode == OP_LOAD_RANGE) &&
                    (32'(in_item.slot) < RANGE_SLOTS);
  assign file_we  = in_accept && (in_item.opcode == OP_LOAD_FILE) &&
                    (32'(in_item.slot) < FILE_SLOTS);

  always_comb begin
    range_wdata.zoom  = in_item.zoom;
    range_wdata.max_x = in_item.max_x;
    range_wdata.min_x = in_item.min_x;
    range_wdata.max_y = in_item.max_y;
    range_wdata.min_y = in_item.min_y;
    range_wdata.base  = in_item.base_offset;
  end

  tral_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (RANGE_SLOTS)
  ) u_range_ram (
    .clk   (clk),
    .we    (range_we),
    .waddr (RAW'(in_item.slot)),
    .wdata (range_wdata),
    .raddr (r_issue[RAW-1:0]),
    .rdata (range_rbits)
  );

  tral_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (FILE_SLOTS)
  ) u_file_ram (
    .clk   (clk),
    .we    (file_we),
    .waddr (FAW'(in_item.slot)),
    .wdata (in_item.file_size),
    .raddr (f_issue[FAW-1:0]),
    .rdata (file_rd)
  );

  assign range_rd = range_entry_t'(range_rbits);
  assign r_more   = (r_issue < range_limit);
  assign f_more   = (f_issue < file_limit);

  assign range_hit = (range_rd.zoom == lk_zoom) &&
                     (lk_x >= range_rd.min_x) && (lk_x <= range_rd.max_x) &&
                     (lk_y >= range_rd.min_y) && (lk_y <= range_rd.max_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      ranges_in_use <= '0;
      files_in_use  <= '0;
      r_rvalid      <= 1'b0;
      f_rvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RANGES_IN_USE) begin
          ranges_in_use <= cfg_data;
        end else if (cfg_index == CFG_FILES_IN_USE) begin
          files_in_use <= cfg_data[3:0];
        end
      end

      if ((state == S_RESULT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            lk_zoom    <= in_item.zoom;
            lk_x       <= in_item.tile_x;
            lk_y       <= in_item.tile_y;
            entry      <= '0;
            res_fnum   <= '0;
            res_foff   <= '0;
            r_issue    <= '0;
            r_rvalid   <= 1'b0;
            f_issue    <= '0;
            f_rvalid   <= 1'b0;
            rest       <= in_item.global_address;
            case (in_item.opcode)
              OP_LOOKUP: begin
                if (in_item.zoom < ZOOM_LEVELS) begin
                  res_status <= STATUS_OK;
                  state      <= S_RSCAN;
                end else begin
                  res_status <= STATUS_NO_RANGE;
                  state      <= S_RESULT;
                end
              end
              OP_MAP: begin
                res_status <= STATUS_OK;
                state      <= S_FSCAN;
              end
              default: begin
                res_status <= STATUS_OK;
                state      <= S_RESULT;
              end
            endcase
          end
        end

        S_RSCAN: begin
          // One read is issued per cycle; its data is checked in the cycle after.
          if (r_more) begin
            r_issue <= r_issue + RLW'(1);
          end
          r_rvalid <= r_more;
          if (r_rvalid && range_hit) begin
            hit_x0   <= range_rd.min_x;
            hit_y0   <= range_rd.min_y;
            hit_y1   <= range_rd.max_y;
            hit_base <= range_rd.base;
            state    <= S_MUL;
          end else if (!r_rvalid && !r_more) begin
            res_status <= STATUS_NO_RANGE;
            state      <= S_RESULT;
          end
        end

        S_MUL: begin
          prod  <= PROD_W'(lk_x - hit_x0) *
                   PROD_W'({1'b0, hit_y1} - {1'b0, hit_y0} + (COORD_W + 1)'(1));
          state <= S_SUM;
        end

        S_SUM: begin
          idx_sum <= SUM_W'(prod) + SUM_W'(lk_y - hit_y0);
          state   <= S_ADDR;
        end

        S_ADDR: begin
          // Index entries are 12 bytes: scale by 8 plus 4.
          entry    <= hit_base + (ADDR_W'(idx_sum) << 3) + (ADDR_W'(idx_sum) << 2);
          rest     <= hit_base + (ADDR_W'(idx_sum) << 3) + (ADDR_W'(idx_sum) << 2);
          f_issue  <= '0;
          f_rvalid <= 1'b0;
          state    <= S_FSCAN;
        end

        S_FSCAN: begin
          if (f_more) begin
            f_issue <= f_issue + FLW'(1);
            f_cmp   <= f_issue[FAW-1:0];
          end
          f_rvalid <= f_more;
          if (f_rvalid) begin
            if (rest < file_rd) begin
              res_status <= STATUS_OK;
              res_fnum   <= FNUM_W'(f_cmp);
              res_foff   <= rest;
              state      <= S_RESULT;
            end else begin
              rest <= rest - file_rd;
            end
          end else if (!f_more) begin
            res_status <= STATUS_BEYOND;
            res_fnum   <= '0;
            res_foff   <= '0;
            state      <= S_RESULT;
          end
        end

        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_item.status        <= res_status;
            out_item.entry_address <= entry;
            out_item.file_number   <= res_fnum;
            out_item.file_offset   <= res_foff;
            state                  <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/tral_ram.sv]
`default_nettype none

module tral_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
